// ===== hw/rtl/cbq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbq_pkg
// Shared types and codes for the circular byte queue.
// ----------------------------------------------------------------------------
package cbq_pkg;

   localparam int DEPTH_DEFAULT    = 64;
   localparam int LEN_W            = 7;
   localparam int QUEUE_LEN_RESET  = 64;

   localparam logic [1:0] REQ_INSERT  = 2'd0;
   localparam logic [1:0] REQ_DELETE  = 2'd1;
   localparam logic [1:0] REQ_DISPLAY = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] data_in;
   } cbq_req_type;

   typedef struct packed {
      logic [7:0]       data_out;
      logic [1:0]       status;
      logic             last_item;
      logic [LEN_W-1:0] fill_count;
   } cbq_rsp_type;

endpackage

// ===== hw/rtl/cbq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbq_ram
// Byte store of the queue: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cbq_ram
   import cbq_pkg::*;
#(
   parameter int DEPTH  = DEPTH_DEFAULT,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/cbq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbq_ctrl
// Request sequencer: ring pointers, fill level, store access, result register.
// ----------------------------------------------------------------------------
module cbq_ctrl
   import cbq_pkg::*;
#(
   parameter int DEPTH  = DEPTH_DEFAULT,
   parameter int PTR_W  = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [LEN_W-1:0]  eff_len,
   input  logic              req_valid,
   output logic              req_stall,
   input  cbq_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cbq_rsp_type       rsp_data,
   output logic              mem_wr_en,
   output logic [PTR_W-1:0]  mem_wr_addr,
   output logic [7:0]        mem_wr_data,
   output logic              mem_rd_en,
   output logic [PTR_W-1:0]  mem_rd_addr,
   input  logic [7:0]        mem_rd_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DELETE,
      ST_DISPLAY
   } state_type;

   state_type        state_ff,     state_in;
   logic [PTR_W-1:0] head_ff,      head_in;
   logic [PTR_W-1:0] tail_ff,      tail_in;
   logic [LEN_W-1:0] fill_ff,      fill_in;
   logic [PTR_W-1:0] scan_ptr_ff,  scan_ptr_in;
   logic [LEN_W-1:0] scan_idx_ff,  scan_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   cbq_rsp_type      rsp_data_ff,  rsp_data_in;

   logic             out_free;
   logic             accept;
   logic             scan_last;
   logic [PTR_W-1:0] scan_next;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] n;
      n = LEN_W'(p) + LEN_W'(1);
      return (n >= len) ? '0 : n[PTR_W-1:0];
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign scan_last = (scan_idx_ff + LEN_W'(1)) == fill_ff;
   assign scan_next = advance(scan_ptr_ff, eff_len);

   assign mem_wr_addr = tail_ff;
   assign mem_wr_data = req_data.data_in;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      scan_ptr_in  = scan_ptr_ff;
      scan_idx_in  = scan_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{data_out: 8'd0, status: STATUS_OK, last_item: 1'b1,
                                fill_count: fill_ff};
               unique case (req_data.req_type)
                  REQ_INSERT: begin
                     if (fill_ff >= eff_len) begin
                        rsp_data_in.status = STATUS_FULL;
                     end else begin
                        mem_wr_en              = 1'b1;
                        tail_in                = advance(tail_ff, eff_len);
                        fill_in                = fill_ff + LEN_W'(1);
                        rsp_data_in.fill_count = fill_ff + LEN_W'(1);
                     end
                  end
                  REQ_DELETE: begin
                     if (fill_ff == '0) begin
                        rsp_data_in.status = STATUS_EMPTY;
                     end else begin
                        // result goes out once the store returns the byte
                        rsp_valid_in = 1'b0;
                        mem_rd_en    = 1'b1;
                        head_in      = advance(head_ff, eff_len);
                        fill_in      = fill_ff - LEN_W'(1);
                        state_in     = ST_DELETE;
                     end
                  end
                  REQ_DISPLAY: begin
                     if (fill_ff == '0) begin
                        rsp_data_in.status = STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        mem_rd_en    = 1'b1;
                        scan_ptr_in  = head_ff;
                        scan_idx_in  = '0;
                        state_in     = ST_DISPLAY;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DELETE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{data_out: mem_rd_data, status: STATUS_OK, last_item: 1'b1,
                                fill_count: fill_ff};
               state_in     = ST_IDLE;
            end
         end
         ST_DISPLAY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{data_out: mem_rd_data, status: STATUS_OK,
                                last_item: scan_last, fill_count: fill_ff};
               if (scan_last) begin
                  state_in = ST_IDLE;
               end else begin
                  // fetch the next slot while this byte is handed out
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = scan_next;
                  scan_ptr_in = scan_next;
                  scan_idx_in = scan_idx_ff + LEN_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         scan_ptr_ff  <= '0;
         scan_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         scan_ptr_ff  <= scan_ptr_in;
         scan_idx_ff  <= scan_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hw/rtl/circular_byte_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_byte_queue_core
// Ring-buffer byte queue with insert, delete and display requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_valid/req_stall with req_data (kind and byte).
//   Results leave on rsp_valid/rsp_stall with rsp_data; a transaction moves
//   at each edge where valid is high and stall is low.
//   csr_wr_en/csr_wr_data set the ring length (1..DEPTH, out of range is
//   clamped); write it only while the block is idle.
// Timing:
//   Insert, a full insert, an empty delete or display and an unused kind
//   need no store read; the result is registered and shows the next cycle.
//   Delete first reads the store, then hands out the byte.
//   Display of N bytes first reads the store, then hands out one result
//   per cycle while rsp_stall is low; the single read port of the byte
//   store sets the pace. One request is in flight at a time.
// Reset:
//   Empties the queue, sets the ring length to 64 (clamped to DEPTH) and
//   drops any pending result. The byte store itself is not cleared.
// Stall:
//   A stalled result holds in the output register; req_stall stays high
//   until it is taken.
// ----------------------------------------------------------------------------
module circular_byte_queue_core
   import cbq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cbq_req_type      req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cbq_rsp_type      rsp_data,
   input  logic             csr_wr_en,
   input  logic [LEN_W-1:0] csr_wr_data
);

   localparam int PTR_W = $clog2(DEPTH);

   logic [LEN_W-1:0] queue_len_ff, queue_len_in;
   logic [LEN_W-1:0] eff_len;

   logic             mem_wr_en;
   logic [PTR_W-1:0] mem_wr_addr;
   logic [7:0]       mem_wr_data;
   logic             mem_rd_en;
   logic [PTR_W-1:0] mem_rd_addr;
   logic [7:0]       mem_rd_data;

   assign queue_len_in = csr_wr_en ? csr_wr_data : queue_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_len_ff <= LEN_W'(QUEUE_LEN_RESET);
      end else begin
         queue_len_ff <= queue_len_in;
      end
   end

   // clamp the programmed length to 1..DEPTH
   always_comb begin
      priority if (queue_len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (queue_len_ff > LEN_W'(DEPTH)) begin
         eff_len = LEN_W'(DEPTH);
      end else begin
         eff_len = queue_len_ff;
      end
   end

   cbq_ctrl #(
      .DEPTH (DEPTH),
      .PTR_W (PTR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .eff_len     (eff_len),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   cbq_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (PTR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// ===== dv/circular_byte_queue_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_byte_queue_core_tb
// Self-checking bench for the ring-buffer byte queue.
// A directed run covers empty and full queues, wrap-around, display and the
// spare request kind. Random phases follow, each at its own ring length,
// with random idle cycles on both channels. A predictor tracks the ring
// contents, and every result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module circular_byte_queue_core_tb
   import cbq_pkg::*;
();

   localparam logic [1:0] REQ_SPARE   = 2'd3;
   localparam int         CYCLE_LIMIT = 1_000_000;

   // ------------------------------------------------------------------------
   // Ring predictor and the results it still owes
   // ------------------------------------------------------------------------
   class byte_queue_scoreboard;
      logic [7:0]       slot_bytes [DEPTH_DEFAULT];
      logic [5:0]       head_pos;
      logic [5:0]       tail_pos;
      logic [LEN_W-1:0] held;
      logic [LEN_W-1:0] length_reg;
      cbq_rsp_type      results_due [$];
      int unsigned      errors;

      function new();
         head_pos   = '0;
         tail_pos   = '0;
         held       = '0;
         length_reg = LEN_W'(QUEUE_LEN_RESET);
         errors     = 0;
         foreach (slot_bytes[i]) slot_bytes[i] = '0;
      endfunction

      function void set_length(logic [LEN_W-1:0] value);
         length_reg = value;
      endfunction

      function int unsigned ring_len();
         if (length_reg == 0) return 1;
         if (length_reg > DEPTH_DEFAULT) return DEPTH_DEFAULT;
         return int'(length_reg);
      endfunction

      function logic [5:0] advance(logic [5:0] p);
         int unsigned n;
         n = p + 1;
         return (n >= ring_len()) ? 6'd0 : n[5:0];
      endfunction

      function void add_result(logic [7:0] d, logic [1:0] s, logic l,
                               logic [LEN_W-1:0] f);
         cbq_rsp_type e;
         e.data_out   = d;
         e.status     = s;
         e.last_item  = l;
         e.fill_count = f;
         results_due.push_back(e);
      endfunction

      function void predict_request(cbq_req_type r);
         logic [5:0] p;
         int unsigned i;
         case (r.req_type)
            REQ_INSERT: begin
               if (held >= ring_len()) begin
                  add_result(8'd0, STATUS_FULL, 1'b1, held);
               end else begin
                  slot_bytes[tail_pos] = r.data_in;
                  tail_pos = advance(tail_pos);
                  held++;
                  add_result(8'd0, STATUS_OK, 1'b1, held);
               end
            end
            REQ_DELETE: begin
               if (held == 0) begin
                  add_result(8'd0, STATUS_EMPTY, 1'b1, held);
               end else begin
                  p = head_pos;
                  head_pos = advance(head_pos);
                  held--;
                  add_result(slot_bytes[p], STATUS_OK, 1'b1, held);
               end
            end
            REQ_DISPLAY: begin
               if (held == 0) begin
                  add_result(8'd0, STATUS_EMPTY, 1'b1, held);
               end else begin
                  p = head_pos;
                  for (i = 0; i < held; i++) begin
                     add_result(slot_bytes[p], STATUS_OK, (i + 1 == held), held);
                     p = advance(p);
                  end
               end
            end
            default: add_result(8'd0, STATUS_OK, 1'b1, held);
         endcase
      endfunction

      function void check_result(cbq_rsp_type got);
         cbq_rsp_type want;
         if (results_due.size() == 0) begin
            $display("%0t unexpected rsp: data=%h status=%0d last=%0b fill=%0d",
                     $time, got.data_out, got.status, got.last_item, got.fill_count);
            errors++;
            return;
         end
         want = results_due.pop_front();
         if (got.data_out !== want.data_out || got.status !== want.status ||
             got.last_item !== want.last_item || got.fill_count !== want.fill_count) begin
            $display("%0t rsp mismatch: expected data=%h status=%0d last=%0b fill=%0d, %s",
                     $time, want.data_out, want.status, want.last_item, want.fill_count,
                     $sformatf("actual data=%h status=%0d last=%0b fill=%0d",
                               got.data_out, got.status, got.last_item, got.fill_count));
            errors++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   cbq_req_type      req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   cbq_rsp_type      rsp_data;
   logic             csr_wr_en;
   logic [LEN_W-1:0] csr_wr_data;

   byte_queue_scoreboard queue_model = new();
   bit                   idle_off;
   int unsigned          cycle_count;

   circular_byte_queue_core #(
      .DEPTH(DEPTH_DEFAULT)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) queue_model.check_result(rsp_data);
   end

   function automatic int unsigned pause_cycles();
      return idle_off ? 0 : $urandom_range(0, 16);
   endfunction

   // Hold stall for a drawn number of cycles, then take one transaction.
   initial begin : rsp_sink
      int unsigned gap;
      rsp_stall = 1'b0;
      forever begin
         gap = pause_cycles();
         @(negedge clock);
         rsp_stall <= (gap != 0);
         if (gap != 0) begin
            repeat (gap - 1) @(negedge clock);
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic send_request(logic [1:0] kind, logic [7:0] value);
      int unsigned gap;
      cbq_req_type r;
      r.req_type = kind;
      r.data_in  = value;
      gap = pause_cycles();
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      queue_model.predict_request(r);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (queue_model.results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Empty the ring first so no slot is read before it is written.
   task automatic write_length(logic [LEN_W-1:0] value);
      while (queue_model.held != 0) send_request(REQ_DELETE, 8'($urandom_range(0, 255)));
      wait_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      queue_model.set_length(value);
   endtask

   task automatic random_phase(int unsigned count, int unsigned insert_pct);
      int unsigned roll;
      logic [1:0] kind;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll >= 96) kind = REQ_SPARE;
         else if (roll < insert_pct) kind = REQ_INSERT;
         else if ($urandom_range(0, 2) == 0) kind = REQ_DISPLAY;
         else kind = REQ_DELETE;
         send_request(kind, 8'($urandom_range(0, 255)));
      end
   endtask

   initial begin : stimulus
      int unsigned phase_len [10];
      int unsigned ph;
      phase_len = '{5, 1, 0, 127, 3, 65, 17, 2, 0, 64};
      phase_len[8] = $urandom_range(1, DEPTH_DEFAULT - 1);
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      idle_off    = 1'b0;
      cycle_count = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Empty queue, spare kind, extreme bytes, display and delete
      send_request(REQ_DELETE, 8'h33);
      send_request(REQ_DISPLAY, 8'hCC);
      send_request(REQ_SPARE, 8'hFF);
      send_request(REQ_INSERT, 8'h00);
      send_request(REQ_INSERT, 8'hFF);
      send_request(REQ_INSERT, 8'hA5);
      send_request(REQ_DISPLAY, 8'h00);
      send_request(REQ_DELETE, 8'h00);
      send_request(REQ_SPARE, 8'h00);
      send_request(REQ_DISPLAY, 8'hFF);
      send_request(REQ_DELETE, 8'hFF);
      send_request(REQ_DELETE, 8'h00);
      send_request(REQ_DELETE, 8'h00);

      // Short ring: full insert and pointer wrap
      write_length(LEN_W'(2));
      send_request(REQ_INSERT, 8'h5A);
      send_request(REQ_INSERT, 8'h01);
      send_request(REQ_INSERT, 8'h80);
      send_request(REQ_DISPLAY, 8'h00);
      send_request(REQ_DELETE, 8'h00);
      send_request(REQ_INSERT, 8'h7E);
      send_request(REQ_DISPLAY, 8'h00);
      send_request(REQ_DELETE, 8'h00);
      send_request(REQ_DELETE, 8'h00);

      for (ph = 0; ph < 10; ph++) begin
         write_length(LEN_W'(phase_len[ph]));
         idle_off = ($urandom_range(0, 2) == 0);
         // Fill the full-depth ring to reach the full status
         if (phase_len[ph] == DEPTH_DEFAULT) random_phase(72, 92);
         else random_phase(3, 55);
      end

      idle_off = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (queue_model.results_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (queue_model.errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
